// File: sv/m4inv_pkg.sv
// Package: widths, state encoding and helpers for the 4x4 matrix inverse unit
package m4inv_pkg;

  localparam int unsigned ELEMENT_BITS_DEF  = 32;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // sequencer phases
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MINOR,
    ST_DET,
    ST_DIV,
    ST_EMIT
  } m4inv_state_t;

  // element index of row r, column c
  function automatic logic [3:0] idx(input logic [1:0] r, input logic [1:0] c);
    idx = {r, c};
  endfunction

  // k-th (0..2) index of 0..3 skipping s
  function automatic logic [1:0] skip(input logic [1:0] s, input logic [1:0] k);
    skip = (k >= s) ? 2'(k + 2'd1) : k;
  endfunction

endpackage

// File: sv/m4inv_if.sv
// Stream interface: valid/ready handshake with a parameterised payload
interface m4inv_in_if #(parameter int unsigned W = 32) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] element;
  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

interface m4inv_out_if #(parameter int unsigned W = 32) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] inv_element;
  logic         singular;
  logic         overflow;
  logic         last;
  modport source (output valid, output inv_element, output singular, output overflow,
                  output last, input ready);
  modport sink   (input valid, input inv_element, input singular, input overflow,
                  input last, output ready);
endinterface

// File: sv/m4inv_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read
module m4inv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: sv/m4inv_div.sv
// Restoring divider, one quotient bit per cycle
module m4inv_div #(
  parameter int unsigned NW = 160,
  parameter int unsigned DW = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] n_r, n_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] d_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [DW+1:0] sh;
  logic [DW+1:0] diff;

  // shift one numerator bit into the remainder, subtract if it fits
  always_comb begin
    sh       = {rem_r, n_r[NW-1]};
    diff     = sh - {2'b00, d_r};
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done     = 1'b0;
    if (start) begin
      n_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DW+1]) begin
        rem_nxt = diff[DW:0];
        n_nxt   = {n_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = sh[DW:0];
        n_nxt   = {n_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done     = 1'b1;
      end
    end
  end

  assign quo = n_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    if (start) d_r <= den;
  end
endmodule

// File: sv/matrix4_inverse_unit.sv
// Top level: 4x4 fixed-point matrix inverse by cofactors, shared multiplier and divider
// Loading: sixteen element transactions, ready held high. Each product is three operand
// read phases, a multiplier start and one digit step per multiplier digit (four at
// defaults); a cofactor is 9 products, the determinant 4. Each quotient comes from the
// divider, skipped when the determinant is zero (singular). Results then follow one per
// accepted cycle. Synchronous reset (rst_n low) returns to loading, count zero.
module matrix4_inverse_unit #(
  parameter int unsigned ELEMENT_BITS  = m4inv_pkg::ELEMENT_BITS_DEF,
  parameter int unsigned FRACTION_BITS = m4inv_pkg::FRACTION_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  m4inv_in_if.sink    in_ch,
  m4inv_out_if.source out_ch
);
  import m4inv_pkg::*;

  localparam int unsigned EB = ELEMENT_BITS;
  localparam int unsigned CB = 3 * EB + 2;   // cofactor width
  localparam int unsigned DB = 4 * EB + 3;   // determinant width
  localparam int unsigned NB = CB + 2 * FRACTION_BITS; // numerator magnitude
  localparam int unsigned PB = EB + CB;      // product width
  localparam int unsigned MD = (CB + EB - 1) / EB;     // multiplier digits of opb
  localparam int unsigned XB = MD * EB;
  localparam int unsigned MCW = $clog2(MD + 1);

  m4inv_state_t state_r, state_nxt;
  logic [3:0] ld_r, ld_nxt;
  logic [3:0] ci_r, ci_nxt;     // cofactor / output index
  logic [3:0] step_r, step_nxt; // sub-step in a cofactor
  logic [1:0] ph_r, ph_nxt;     // read phase 0..3

  // matrix store
  logic          ram_we;
  logic [3:0]    ram_ra;
  logic [EB-1:0] ram_rd;
  m4inv_ram #(.WIDTH(EB), .DEPTH(16)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ld_r), .wdata(in_ch.element),
    .raddr(ram_ra), .rdata(ram_rd)
  );

  // operand latches and accumulators
  logic signed [EB-1:0] opa_r;
  logic signed [CB-1:0] opb_r;
  logic signed [PB-1:0] prod;
  logic signed [CB-1:0] t_r [3];
  logic signed [CB-1:0] acc_r;
  logic signed [CB-1:0] cof_r [16];
  logic signed [DB-1:0] det_r;
  logic [EB-1:0] res_r [16];
  logic [15:0]   ovf_r;
  logic          sing_r;

  // shared multiplier: opa times one EB-bit digit of opb per cycle, top digit first
  // (signed), the lower digits unsigned; product ready on the last digit cycle
  logic                 mul_start, mul_done;
  logic [XB-1:0]        mb_r, mb_nxt;
  logic [PB-1:0]        macc_r, macc_nxt;
  logic [MCW-1:0]       mcnt_r, mcnt_nxt;
  logic signed [EB:0]   mdig;
  logic signed [2*EB:0] mpp;
  assign mul_done = (mcnt_r == MCW'(1));
  always_comb begin
    mdig     = (mcnt_r == MCW'(MD)) ? $signed({mb_r[XB-1], mb_r[XB-1 -: EB]})
                                    : $signed({1'b0, mb_r[XB-1 -: EB]});
    mpp      = (2*EB+1)'(opa_r) * (2*EB+1)'(mdig);
    macc_nxt = macc_r;
    mb_nxt   = mb_r;
    mcnt_nxt = mcnt_r;
    if (mcnt_r != '0) begin
      macc_nxt = (macc_r << EB) + PB'(mpp);
      mb_nxt   = mb_r << EB;
      mcnt_nxt = mcnt_r - 1'b1;
    end else if (mul_start) begin
      macc_nxt = '0;
      mb_nxt   = XB'(opb_r);
      mcnt_nxt = MCW'(MD);
    end
  end
  assign prod = macc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) mcnt_r <= '0;
    else        mcnt_r <= mcnt_nxt;
    macc_r <= macc_nxt;
    mb_r   <= mb_nxt;
  end

  // cofactor addressing: adjugate (r,c) = minor removing row c, column r
  logic [1:0] cr, cc;
  logic [1:0] rr [3];
  logic [1:0] kk [3];
  assign cr = ci_r[3:2];
  assign cc = ci_r[1:0];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rr[k] = skip(cc, 2'(k));
      kk[k] = skip(cr, 2'(k));
    end
  end

  // step plan: steps 0..11 are the six 2x2 products (two reads each: a then b),
  // steps 12..14 are the three outer products (one read, one t)
  logic [3:0] addr_a, addr_b;
  logic [1:0] pt;  // which t
  logic       pneg;
  always_comb begin
    unique case (step_r[3:1])
      3'd0: begin addr_a = idx(rr[1], kk[1]); addr_b = idx(rr[2], kk[2]); end
      3'd1: begin addr_a = idx(rr[1], kk[2]); addr_b = idx(rr[2], kk[1]); end
      3'd2: begin addr_a = idx(rr[1], kk[0]); addr_b = idx(rr[2], kk[2]); end
      3'd3: begin addr_a = idx(rr[1], kk[2]); addr_b = idx(rr[2], kk[0]); end
      3'd4: begin addr_a = idx(rr[1], kk[0]); addr_b = idx(rr[2], kk[1]); end
      3'd5: begin addr_a = idx(rr[1], kk[1]); addr_b = idx(rr[2], kk[0]); end
      default: begin addr_a = idx(rr[0], kk[2'(step_r - 4'd12)]); addr_b = '0; end
    endcase
    pt   = 2'(step_r[3:1] >> 1);
    pneg = step_r[1];
  end

  // divider
  logic          dv_start, dv_done;
  logic [NB-1:0] dv_quo;
  logic [NB-1:0] dv_num;
  logic [DB-1:0] dmag;
  logic          dneg, cneg, rneg;
  logic [CB-1:0] cmag;
  assign dneg = det_r[DB-1];
  assign dmag = dneg ? DB'(-det_r) : DB'(det_r);
  assign cneg = cof_r[ci_r][CB-1];
  assign cmag = cneg ? CB'(-cof_r[ci_r]) : CB'(cof_r[ci_r]);
  assign dv_num = {cmag, (2*FRACTION_BITS)'(0)};
  assign rneg = cneg ^ dneg;

  m4inv_div #(.NW(NB), .DW(DB)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(dmag),
    .done(dv_done), .quo(dv_quo)
  );

  // saturation of the quotient magnitude
  localparam logic [NB-1:0] LIM_P = NB'({1'b0, {(EB-1){1'b1}}});
  logic          q_ovf;
  logic [EB-1:0] q_val;
  always_comb begin
    q_ovf = rneg ? (dv_quo > LIM_P + NB'(1)) : (dv_quo > LIM_P);
    if (q_ovf) q_val = rneg ? {1'b1, {(EB-1){1'b0}}} : {1'b0, {(EB-1){1'b1}}};
    else       q_val = rneg ? EB'(-dv_quo[EB-1:0]) : dv_quo[EB-1:0];
  end

  logic div_busy_r, div_busy_nxt;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    ld_nxt       = ld_r;
    ci_nxt       = ci_r;
    step_nxt     = step_r;
    ph_nxt       = ph_r;
    ram_we       = 1'b0;
    ram_ra       = addr_a;
    dv_start     = 1'b0;
    mul_start    = 1'b0;
    div_busy_nxt = div_busy_r;
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          ram_we = 1'b1;
          ld_nxt = ld_r + 4'd1;
          if (ld_r == 4'd15) begin
            state_nxt = ST_MINOR;
            ci_nxt = '0; step_nxt = '0; ph_nxt = '0;
          end
        end
      end
      ST_MINOR: begin
        // ph0: issue read a; ph1: latch a, issue read b; ph2: latch b (or t);
        // ph3: start the multiplier, accumulate when its product is ready
        ram_ra = (ph_r == 2'd1) ? addr_b : addr_a;
        if (ph_r != 2'd3) begin
          ph_nxt = ph_r + 2'd1;
        end else if (mcnt_r == '0) begin
          mul_start = 1'b1;
        end else if (mul_done) begin
          ph_nxt = '0;
          if (step_r < 4'd12) step_nxt = step_r + 4'd2;
          else                step_nxt = step_r + 4'd1;
          if (step_r == 4'd14) begin
            step_nxt = '0;
            ci_nxt = ci_r + 4'd1;
            if (ci_r == 4'd15) state_nxt = ST_DET;
          end
        end
      end
      ST_DET: begin
        ram_ra = ci_r[1:0] == 2'd0 ? 4'd0 : {2'b00, ci_r[1:0]};
        if (ph_r != 2'd3) begin
          ph_nxt = ph_r + 2'd1;
        end else if (mcnt_r == '0) begin
          mul_start = 1'b1;
        end else if (mul_done) begin
          ph_nxt = '0;
          ci_nxt = ci_r + 4'd1;
          if (ci_r == 4'd3) begin
            state_nxt = ST_DIV; ci_nxt = '0;
          end
        end
      end
      ST_DIV: begin
        if (det_r == '0) begin
          state_nxt = ST_EMIT; ci_nxt = '0;
        end else if (!div_busy_r) begin
          dv_start = 1'b1; div_busy_nxt = 1'b1;
        end else if (dv_done) begin
          div_busy_nxt = 1'b0;
          ci_nxt = ci_r + 4'd1;
          if (ci_r == 4'd15) begin state_nxt = ST_EMIT; ci_nxt = '0; end
        end
      end
      ST_EMIT: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          ci_nxt = ci_r + 4'd1;
          if (ci_r == 4'd15) begin state_nxt = ST_LOAD; ci_nxt = '0; end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      ld_r       <= '0;
      ci_r       <= '0;
      step_r     <= '0;
      ph_r       <= '0;
      div_busy_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ld_r       <= ld_nxt;
      ci_r       <= ci_nxt;
      step_r     <= step_nxt;
      ph_r       <= ph_nxt;
      div_busy_r <= div_busy_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_MINOR: begin
        if (ph_r == 2'd1) opa_r <= ram_rd;
        if (ph_r == 2'd2) begin
          if (step_r < 4'd12) opb_r <= CB'($signed(ram_rd));
          else                opb_r <= t_r[2'(step_r - 4'd12)];
        end
        if (ph_r == 2'd3 && mul_done) begin
          if (step_r < 4'd12) begin
            if (!pneg) t_r[pt] <= CB'(prod);
            else       t_r[pt] <= t_r[pt] - CB'(prod);
          end else begin
            logic signed [CB-1:0] a2;
            a2 = (step_r == 4'd12) ? CB'(prod)
               : (step_r == 4'd13) ? acc_r - CB'(prod) : acc_r + CB'(prod);
            acc_r <= a2;
            if (step_r == 4'd14) cof_r[ci_r] <= (cr[0] ^ cc[0]) ? -a2 : a2;
          end
        end
      end
      ST_DET: begin
        if (ph_r == 2'd1) begin
          opa_r <= ram_rd;
          opb_r <= cof_r[{ci_r[1:0], 2'b00}];
        end
        if (ph_r == 2'd3 && mul_done) begin
          if (ci_r == 4'd0) det_r <= DB'(prod);
          else              det_r <= det_r + DB'(prod);
        end
      end
      ST_DIV: begin
        sing_r <= (det_r == '0);
        if (det_r == '0) begin
          ovf_r <= '0;
          for (int i = 0; i < 16; i++) res_r[i] <= '0;
        end else if (div_busy_r && dv_done) begin
          res_r[ci_r] <= q_val;
          ovf_r[ci_r] <= q_ovf;
        end
      end
      default: ;
    endcase
  end

  // result channel
  assign out_ch.inv_element = res_r[ci_r];
  assign out_ch.singular    = sing_r;
  assign out_ch.overflow    = ovf_r[ci_r];
  assign out_ch.last        = (ci_r == 4'd15);
endmodule

// File: sv/m4inv_checker.sv
// Port-level checker for the matrix inverse unit, bound to the top level
module m4inv_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_singular,
  input logic out_overflow,
  input logic out_last
);
  // no input taken while results are pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready while emitting");

  // a singular run never flags overflow
  a_sing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> !out_overflow) else $error("singular with overflow");

  // singular flag constant across one run
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && $stable(out_singular))
    else $error("singular flag changed in run");

  // stalled output stays valid with its last flag unchanged
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_last))
    else $error("stalled result changed");
endmodule

bind matrix4_inverse_unit m4inv_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_singular(out_ch.singular), .out_overflow(out_ch.overflow),
  .out_last(out_ch.last)
);

// File: sim/tb_top.sv
// Testbench for matrix4_inverse_unit: random and directed matrices against a wide predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import m4inv_pkg::*;

  localparam int unsigned EB = ELEMENT_BITS_DEF;
  localparam int unsigned FB = FRACTION_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [EB-1:0] ONE_Q = EB'(1) << FB;
  localparam logic [EB-1:0] MAX_Q = {1'b0, {(EB-1){1'b1}}};
  localparam logic [EB-1:0] MIN_Q = {1'b1, {(EB-1){1'b0}}};

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic [EB-1:0] inv_element;
    logic          singular;
    logic          overflow;
    logic          last;
  } inv_result_t;

  logic clk;
  logic rst_n;

  m4inv_in_if  #(EB) in_ch  ();
  m4inv_out_if #(EB) out_ch ();

  matrix4_inverse_unit #(.ELEMENT_BITS(EB), .FRACTION_BITS(FB)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock: 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  logic [EB-1:0] pending_elements[$];
  inv_result_t   expected_inverse[$];
  logic [EB-1:0] loaded_matrix[16];
  int            load_slot;
  int            error_count;
  int            matrices_done;
  int            singular_seen;
  int            overflow_seen;
  int            cycle_count;
  bit            quiet_phase;

  // wait draw: random value 0..14, zero during a quiet phase
  function automatic int draw_wait();
    return quiet_phase ? 0 : int'($urandom_range(0, 14));
  endfunction

  // signed minor for adjugate entry (r,c): drop row c and column r
  function automatic wide_t adj_entry(input wide_t m[16], input int r, input int c);
    int    rows[3];
    int    cols[3];
    int    k;
    int    l;
    wide_t t0;
    wide_t t1;
    wide_t t2;
    wide_t d;
    k = 0;
    l = 0;
    for (int i = 0; i < 4; i++) begin
      if (i != c) begin
        rows[k] = i;
        k++;
      end
      if (i != r) begin
        cols[l] = i;
        l++;
      end
    end
    t0 = m[rows[1]*4+cols[1]] * m[rows[2]*4+cols[2]]
       - m[rows[1]*4+cols[2]] * m[rows[2]*4+cols[1]];
    t1 = m[rows[1]*4+cols[0]] * m[rows[2]*4+cols[2]]
       - m[rows[1]*4+cols[2]] * m[rows[2]*4+cols[0]];
    t2 = m[rows[1]*4+cols[0]] * m[rows[2]*4+cols[1]]
       - m[rows[1]*4+cols[1]] * m[rows[2]*4+cols[0]];
    d = m[rows[0]*4+cols[0]] * t0 - m[rows[0]*4+cols[1]] * t1
      + m[rows[0]*4+cols[2]] * t2;
    return ((r + c) % 2 == 1) ? -d : d;
  endfunction

  // whole matrix loaded: queue the sixteen inverse elements
  task automatic predict_inverse();
    wide_t         m[16];
    wide_t         cof[16];
    wide_t         det;
    logic [255:0]  dmag;
    logic [255:0]  num;
    logic [255:0]  quot;
    logic [255:0]  lim;
    logic          neg;
    inv_result_t   res;
    for (int i = 0; i < 16; i++) m[i] = wide_t'($signed(loaded_matrix[i]));
    for (int i = 0; i < 16; i++) cof[i] = adj_entry(m, i / 4, i % 4);
    det = 0;
    for (int i = 0; i < 4; i++) det = det + m[i] * cof[i*4];
    for (int i = 0; i < 16; i++) begin
      res = '0;
      res.last = (i == 15);
      if (det == 0) begin
        res.singular = 1'b1;
      end else begin
        dmag = (det < 0) ? -det : det;
        neg  = (cof[i] < 0) != (det < 0);
        num  = ((cof[i] < 0) ? -cof[i] : cof[i]);
        num  = num << (2 * FB);
        quot = num / dmag;
        lim  = neg ? 256'(MIN_Q) : 256'(MAX_Q);
        if (quot > lim) begin
          res.overflow    = 1'b1;
          res.inv_element = neg ? MIN_Q : MAX_Q;
        end else begin
          res.inv_element = neg ? EB'(-quot) : EB'(quot);
        end
      end
      expected_inverse.push_back(res);
    end
  endtask

  // driver: one element per transaction, random gap before each
  int in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.element <= '0;
      in_gap        <= draw_wait();
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      if (in_gap > 0) begin
        in_gap      <= in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_elements.size() > 0) begin
        in_ch.element <= pending_elements.pop_front();
        in_ch.valid   <= 1'b1;
        in_gap        <= draw_wait();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // accepted input transactions feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      loaded_matrix[load_slot] = in_ch.element;
      if (load_slot == 15) begin
        load_slot = 0;
        predict_inverse();
      end else begin
        load_slot = load_slot + 1;
      end
    end
  end

  // result side back-pressure
  int out_stall;
  always @(posedge clk) begin
    int s;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall    <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      s = draw_wait();
      out_stall    <= s;
      out_ch.ready <= (s == 0);
    end else if (out_stall > 0) begin
      out_stall    <= out_stall - 1;
      out_ch.ready <= (out_stall == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    inv_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_inverse.size() == 0) begin
        $display("%0t: unexpected result inv=%h sing=%b ovf=%b last=%b", $time,
                 out_ch.inv_element, out_ch.singular, out_ch.overflow, out_ch.last);
        error_count++;
      end else begin
        exp_r = expected_inverse.pop_front();
        if (out_ch.inv_element !== exp_r.inv_element)
          $display("%0t: inv_element expected %h actual %h", $time,
                   exp_r.inv_element, out_ch.inv_element);
        if (out_ch.singular !== exp_r.singular)
          $display("%0t: singular expected %b actual %b", $time, exp_r.singular, out_ch.singular);
        if (out_ch.overflow !== exp_r.overflow)
          $display("%0t: overflow expected %b actual %b", $time, exp_r.overflow, out_ch.overflow);
        if (out_ch.last !== exp_r.last)
          $display("%0t: last expected %b actual %b", $time, exp_r.last, out_ch.last);
        if (out_ch.inv_element !== exp_r.inv_element || out_ch.singular !== exp_r.singular ||
            out_ch.overflow !== exp_r.overflow || out_ch.last !== exp_r.last)
          error_count++;
        if (exp_r.singular) singular_seen++;
        if (exp_r.overflow) overflow_seen++;
        if (exp_r.last) begin
          matrices_done++;
          quiet_phase = ($urandom_range(0, 3) == 0);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_matrix(input logic [EB-1:0] mat[16]);
    for (int i = 0; i < 16; i++) pending_elements.push_back(mat[i]);
  endtask

  // random matrix of one of several flavours
  task automatic push_random_matrix();
    logic [EB-1:0] mat[16];
    int            flavour;
    int            pick;
    pick = $urandom_range(0, 9);
    flavour = (pick < 4) ? 0 : (pick < 6) ? 1 : (pick < 8) ? 2 : 3;
    for (int i = 0; i < 16; i++) begin
      case (flavour)
        0: mat[i] = EB'($signed(int'($urandom_range(0, 32'h80000))) - 32'sh40000);
        1: mat[i] = EB'($urandom);
        2: mat[i] = (i / 4 == i % 4) ? EB'($urandom_range(1, 255)) : EB'(0);
        default: mat[i] = EB'($urandom_range(0, 7)) << FB;
      endcase
    end
    // duplicate a row now and then for a singular matrix
    if ($urandom_range(0, 4) == 0)
      for (int j = 0; j < 4; j++) mat[12 + j] = mat[j];
    push_matrix(mat);
  endtask

  initial begin
    logic [EB-1:0] mat[16];
    rst_n        = 1'b0;
    load_slot    = 0;
    error_count  = 0;
    matrices_done = 0;
    singular_seen = 0;
    overflow_seen = 0;
    cycle_count  = 0;
    quiet_phase  = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.element = '0;
    out_ch.ready  = 1'b0;

    // directed: diagonal with +1.0, -1.0, smallest step and largest value
    foreach (mat[i]) mat[i] = '0;
    mat[0]  = ONE_Q;
    mat[5]  = -ONE_Q;
    mat[10] = EB'(1);
    mat[15] = MAX_Q;
    push_matrix(mat);
    // directed: singular, most negative value in every slot
    foreach (mat[i]) mat[i] = MIN_Q;
    push_matrix(mat);
    for (int n = 0; n < 6; n++) push_random_matrix();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_elements.size() > 0 || in_ch.valid || expected_inverse.size() > 0)
      @(posedge clk);
    // the divider is idle once the last result has gone; allow a little extra
    repeat (200) @(posedge clk);

    if (expected_inverse.size() > 0) begin
      $display("%0t: %0d results never arrived", $time, expected_inverse.size());
      error_count++;
    end
    $display("covered %0d matrices: %0d singular results, %0d saturated results",
             matrices_done, singular_seen, overflow_seen);
    $display("random gaps and stalls on both channels, with quiet phases between");
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
